// ----- hdl/gga_position_time_parser_core_macros.svh -----
// Assertion macros for the GGA position/time parser.
// Every macro samples on the rising edge of clock and is quiet while reset is high.
`ifndef GGA_POSITION_TIME_PARSER_CORE_MACROS_SVH
`define GGA_POSITION_TIME_PARSER_CORE_MACROS_SVH

// Property that must hold at every edge.
`define GPTP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// If pre holds at an edge, then post holds at the next edge.
`define GPTP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/gptp_pkg.sv -----
// Shared types, character codes, field codes and small constant tables
// for the GGA position/time parser. No dependencies.
package gptp_pkg;

   // ASCII characters the parser reacts to
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // Field numbers within a sentence
   localparam logic [2:0] FIELD_HEAD     = 3'd0;
   localparam logic [2:0] FIELD_TIME     = 3'd1;
   localparam logic [2:0] FIELD_LAT      = 3'd2;
   localparam logic [2:0] FIELD_LAT_HEMI = 3'd3;
   localparam logic [2:0] FIELD_LON      = 3'd4;
   localparam logic [2:0] FIELD_LON_HEMI = 3'd5;
   localparam logic [2:0] FIELD_DONE     = 3'd6;

   // One output record
   typedef struct packed {
      logic [6:0] time_hour;
      logic [6:0] time_minute;
      logic [6:0] time_second;
      logic [9:0] time_millisecond;
      logic [7:0] lat_hemi_char;
      logic [6:0] lat_degrees;
      logic [6:0] lat_minutes;
      logic [5:0] lat_seconds;
      logic [7:0] lon_hemi_char;
      logic [6:0] lon_degrees;
      logic [6:0] lon_minutes;
      logic [5:0] lon_seconds;
   } gptp_rec_type;

   // Controls for the arc-seconds accumulator
   typedef struct packed {
      logic clear;     // start of a coordinate field
      logic take;      // a character of a coordinate field
      logic is_point;  // that character is a '.'
   } gptp_frac_ctl_type;

   // Digit value, non-digits read as zero
   function automatic logic [3:0] digit_of(input logic [7:0] c);
      logic [7:0] diff;
      diff = c - CHAR_ZERO;
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ? diff[3:0] : 4'd0;
   endfunction

   // Powers of ten up to 10^6
   function automatic logic [19:0] pow10_f(input logic [2:0] k);
      logic [19:0] v;
      unique case (k)
         3'd0:    v = 20'd1;
         3'd1:    v = 20'd10;
         3'd2:    v = 20'd100;
         3'd3:    v = 20'd1000;
         3'd4:    v = 20'd10000;
         3'd5:    v = 20'd100000;
         3'd6:    v = 20'd1000000;
         default: v = 20'd1;
      endcase
      return v;
   endfunction

   // Tens digit of 6*d
   function automatic logic [2:0] six_tens_f(input logic [3:0] d);
      logic [2:0] v;
      unique case (d)
         4'd2, 4'd3: v = 3'd1;
         4'd4:       v = 3'd2;
         4'd5, 4'd6: v = 3'd3;
         4'd7, 4'd8: v = 3'd4;
         4'd9:       v = 3'd5;
         default:    v = 3'd0;
      endcase
      return v;
   endfunction

   // Units digit of 6*d
   function automatic logic [3:0] six_ones_f(input logic [3:0] d);
      logic [3:0] v;
      unique case (d)
         4'd1, 4'd6: v = 4'd6;
         4'd2, 4'd7: v = 4'd2;
         4'd3, 4'd8: v = 4'd8;
         4'd4, 4'd9: v = 4'd4;
         default:    v = 4'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/gptp_sec_acc.sv -----
// Arc-seconds accumulator: keeps floor(fraction * 60) and its remainder
// digit by digit. Depends on gptp_pkg and the macros header.
`include "gga_position_time_parser_core_macros.svh"

module gptp_sec_acc import gptp_pkg::*; #(
   parameter int unsigned FRAC_DIGITS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  gptp_frac_ctl_type ctl,
   input  logic [3:0]        digit,
   output logic [5:0]        seconds
);

   localparam int unsigned DENOM = 10 ** FRAC_DIGITS;
   localparam int unsigned RW    = $clog2(DENOM);
   localparam int unsigned CW    = $clog2(FRAC_DIGITS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(FRAC_DIGITS);
   localparam logic [CW-1:0] COUNT_ONE = CW'(1);
   localparam logic [RW:0]   DENOM_W   = (RW + 1)'(DENOM);
   localparam logic [2:0]    FD3       = 3'(FRAC_DIGITS);

   logic          point_ff, point_in;
   logic [CW-1:0] count_ff, count_in;
   logic [5:0]    q_ff, q_in;
   logic [RW-1:0] r_ff, r_in;

   logic [5:0]  six_d;
   logic [2:0]  shift_k;
   logic [19:0] weight;
   logic [5:0]  term_q;
   logic [19:0] term_r;
   logic [RW:0] r_sum;
   logic [RW:0] r_wrapped;
   logic        wrap;

   // Each fraction digit adds 60*d*10^(FRAC_DIGITS-1-i); split it into
   // whole seconds and a remainder over 10^FRAC_DIGITS.
   always_comb begin
      six_d   = ({2'b00, digit} << 2) + ({2'b00, digit} << 1);
      shift_k = FD3 - 3'(count_ff);
      weight  = pow10_f(shift_k);
      priority if (count_ff == '0) begin
         term_q = six_d;
         term_r = 20'd0;
      end else if (count_ff == COUNT_ONE) begin
         term_q = {3'b000, six_tens_f(digit)};
         term_r = {16'd0, six_ones_f(digit)} * weight;
      end else begin
         term_q = 6'd0;
         term_r = {14'd0, six_d} * weight;
      end
      r_sum     = {1'b0, r_ff} + (RW + 1)'(term_r);
      wrap      = (r_sum >= DENOM_W);
      r_wrapped = r_sum - DENOM_W;
   end

   // Next state
   always_comb begin
      point_in = point_ff;
      count_in = count_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      if (ctl.clear) begin
         point_in = 1'b0;
         count_in = '0;
         q_in     = 6'd0;
         r_in     = '0;
      end else if (ctl.take) begin
         if (point_ff) begin
            if (count_ff < COUNT_MAX) begin
               count_in = count_ff + COUNT_ONE;
               q_in     = q_ff + term_q + {5'd0, wrap};
               r_in     = wrap ? r_wrapped[RW-1:0] : r_sum[RW-1:0];
            end
         end else if (ctl.is_point) begin
            point_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff <= 1'b0;
         count_ff <= '0;
         q_ff     <= 6'd0;
         r_ff     <= '0;
      end else begin
         point_ff <= point_in;
         count_ff <= count_in;
         q_ff     <= q_in;
         r_ff     <= r_in;
      end
   end

   assign seconds = q_ff;

   `GPTP_ASSERT(a_sec_range, q_ff <= 6'd59, "arc seconds out of range")
   `GPTP_ASSERT(a_rem_range, {1'b0, r_ff} < DENOM_W, "seconds remainder not reduced")
   `GPTP_ASSERT(a_count_range, count_ff <= COUNT_MAX, "fraction digit count overran")
   `GPTP_ASSERT_NEXT(a_clear_zero, ctl.clear, q_ff == 6'd0 && count_ff == '0 && !point_ff,
      "accumulator not cleared")

endmodule

// ----- hdl/gptp_parse.sv -----
// Sentence field tracker: time digits, coordinate digits, hemisphere
// characters and record assembly. Depends on gptp_pkg and gptp_sec_acc.
module gptp_parse import gptp_pkg::*; #(
   parameter int unsigned FRAC_DIGITS = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   in_char,
   output logic         emit,
   output gptp_rec_type rec
);

   localparam logic [3:0] POS_LAST = 4'd15;

   logic [2:0] field_ff, field_in;
   logic [3:0] pos_ff, pos_in;
   logic [6:0] hour_ff, hour_in, minute_ff, minute_in, second_ff, second_in;
   logic [9:0] milli_ff, milli_in;
   logic [6:0] deg_ff, deg_in, min_ff, min_in;
   logic [7:0] lat_hemi_ff, lat_hemi_in;
   logic [6:0] lat_deg_ff, lat_deg_in, lat_min_ff, lat_min_in;
   logic [5:0] lat_sec_ff, lat_sec_in;
   logic [7:0] lon_hemi_ff, lon_hemi_in;
   logic [5:0] lon_sec_ff, lon_sec_in;

   logic [3:0]        d;
   logic [6:0]        d_x10;
   logic [9:0]        d_x100;
   logic [6:0]        d_w;
   logic              is_dollar, is_comma, is_coord;
   gptp_frac_ctl_type frac_ctl;
   logic [5:0]        seconds;

   // Character decode
   always_comb begin
      d         = digit_of(in_char);
      d_w       = {3'b000, d};
      d_x10     = (d_w << 3) + (d_w << 1);
      d_x100    = {6'd0, d} * 10'd100;
      is_dollar = (in_char == CHAR_DOLLAR);
      is_comma  = (in_char == CHAR_COMMA);
      is_coord  = (field_ff == FIELD_LAT) || (field_ff == FIELD_LON);
      emit      = is_comma && (field_ff == FIELD_LON_HEMI);
   end

   // Fraction accumulator control
   always_comb begin
      frac_ctl.clear    = step && is_comma &&
                          (field_ff == FIELD_TIME || field_ff == FIELD_LAT_HEMI);
      frac_ctl.take     = step && !is_dollar && !is_comma && is_coord;
      frac_ctl.is_point = (in_char == CHAR_POINT);
   end

   gptp_sec_acc #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_sec_acc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (frac_ctl),
      .digit   (d),
      .seconds (seconds)
   );

   // Record as it leaves on the comma closing the longitude hemisphere
   always_comb begin
      rec.time_hour        = hour_ff;
      rec.time_minute      = minute_ff;
      rec.time_second      = second_ff;
      rec.time_millisecond = milli_ff;
      rec.lat_hemi_char    = lat_hemi_ff;
      rec.lat_degrees      = lat_deg_ff;
      rec.lat_minutes      = lat_min_ff;
      rec.lat_seconds      = lat_sec_ff;
      rec.lon_hemi_char    = lon_hemi_ff;
      rec.lon_degrees      = deg_ff;
      rec.lon_minutes      = min_ff;
      rec.lon_seconds      = lon_sec_ff;
   end

   // Field and digit update
   always_comb begin
      field_in    = field_ff;
      pos_in      = pos_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      milli_in    = milli_ff;
      deg_in      = deg_ff;
      min_in      = min_ff;
      lat_hemi_in = lat_hemi_ff;
      lat_deg_in  = lat_deg_ff;
      lat_min_in  = lat_min_ff;
      lat_sec_in  = lat_sec_ff;
      lon_hemi_in = lon_hemi_ff;
      lon_sec_in  = lon_sec_ff;
      if (step) begin
         priority if (is_dollar) begin
            field_in = FIELD_HEAD;
            pos_in   = 4'd1;
         end else if (is_comma) begin
            // close the current field
            if (field_ff == FIELD_LAT) begin
               lat_sec_in  = seconds;
               lat_min_in  = min_ff;
               lat_deg_in  = deg_ff;
               lat_hemi_in = 8'd0;
            end else if (field_ff == FIELD_LON) begin
               lon_sec_in  = seconds;
               lon_hemi_in = 8'd0;
            end
            // open the next one
            if (field_ff < FIELD_DONE) begin
               field_in = field_ff + 3'd1;
               unique case (field_ff)
                  FIELD_HEAD: begin
                     hour_in   = 7'd0;
                     minute_in = 7'd0;
                     second_in = 7'd0;
                     milli_in  = 10'd0;
                  end
                  FIELD_TIME, FIELD_LAT_HEMI: begin
                     deg_in = 7'd0;
                     min_in = 7'd0;
                  end
                  default: begin
                  end
               endcase
            end
            pos_in = 4'd0;
         end else begin
            unique case (field_ff)
               FIELD_TIME: begin
                  unique case (pos_ff)
                     4'd0:    hour_in   = d_x10;
                     4'd1:    hour_in   = hour_ff + d_w;
                     4'd2:    minute_in = d_x10;
                     4'd3:    minute_in = minute_ff + d_w;
                     4'd4:    second_in = d_x10;
                     4'd5:    second_in = second_ff + d_w;
                     4'd7:    milli_in  = d_x100;
                     4'd8:    milli_in  = milli_ff + {3'b000, d_x10};
                     4'd9:    milli_in  = milli_ff + {6'd0, d};
                     default: begin
                     end
                  endcase
               end
               FIELD_LAT, FIELD_LON: begin
                  unique case (pos_ff)
                     4'd0:    deg_in = d_x10;
                     4'd1:    deg_in = deg_ff + d_w;
                     4'd2:    min_in = d_x10;
                     4'd3:    min_in = min_ff + d_w;
                     default: begin
                     end
                  endcase
               end
               FIELD_LAT_HEMI: begin
                  if (pos_ff == 4'd0) lat_hemi_in = in_char;
               end
               FIELD_LON_HEMI: begin
                  if (pos_ff == 4'd0) lon_hemi_in = in_char;
               end
               default: begin
               end
            endcase
            if (pos_ff != POS_LAST) pos_in = pos_ff + 4'd1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= FIELD_HEAD;
         pos_ff   <= 4'd0;
      end else begin
         field_ff <= field_in;
         pos_ff   <= pos_in;
      end
   end

   // Held digits and records
   always_ff @(posedge clock) begin
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      second_ff   <= second_in;
      milli_ff    <= milli_in;
      deg_ff      <= deg_in;
      min_ff      <= min_in;
      lat_hemi_ff <= lat_hemi_in;
      lat_deg_ff  <= lat_deg_in;
      lat_min_ff  <= lat_min_in;
      lat_sec_ff  <= lat_sec_in;
      lon_hemi_ff <= lon_hemi_in;
      lon_sec_ff  <= lon_sec_in;
   end

endmodule

// ----- hdl/gptp_in_stage.sv -----
// Input register for the character channel: holds one character until
// the parser consumes it. Depends on gptp_pkg.
module gptp_in_stage import gptp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_char
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;

   // Take a new character whenever the held one is empty or being consumed
   always_comb begin
      req_ready = !valid_ff || advance;
      valid_in  = req_ready ? req_valid : valid_ff;
      char_in   = (req_valid && req_ready) ? req_in_char : char_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign in_valid = valid_ff;
   assign in_char  = char_ff;

endmodule

// ----- hdl/gptp_out_stage.sv -----
// Output register for the record channel: holds one record until the
// consumer takes it. Depends on gptp_pkg.
module gptp_out_stage import gptp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  gptp_rec_type rec,
   output logic         out_free,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output gptp_rec_type rsp_rec
);

   logic         valid_ff, valid_in;
   gptp_rec_type rec_ff, rec_in;

   // Slot frees up on the same edge the consumer takes the record
   always_comb begin
      out_free = !valid_ff || rsp_ready;
      priority if (load) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
      else valid_in = valid_ff;
      rec_in = load ? rec : rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_rec   = rec_ff;

endmodule

// ----- hdl/gga_position_time_parser_core.sv -----
// Channel   Dir  Handshake            Payload
// req_      in   req_valid/req_ready  req_in_char (one ASCII character)
// rsp_      out  rsp_valid/rsp_ready  time, latitude and longitude record
//
// One character per cycle unless stalled. A character accepted into the input register
// is parsed as it is consumed; a record it closes is loaded into the output register.
// The only stall: a comma that closes a record waits while the output register
// still holds a record the consumer has not taken.
// Reset is synchronous and clears field tracking, seconds state and both valid flags.
// Depends on gptp_pkg, gptp_in_stage, gptp_parse, gptp_out_stage and the macros header.
`include "gga_position_time_parser_core_macros.svh"

module gga_position_time_parser_core import gptp_pkg::*; #(
   parameter int unsigned FRAC_DIGITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_time_hour,
   output logic [6:0] rsp_time_minute,
   output logic [6:0] rsp_time_second,
   output logic [9:0] rsp_time_millisecond,
   output logic [7:0] rsp_lat_hemi_char,
   output logic [6:0] rsp_lat_degrees,
   output logic [6:0] rsp_lat_minutes,
   output logic [5:0] rsp_lat_seconds,
   output logic [7:0] rsp_lon_hemi_char,
   output logic [6:0] rsp_lon_degrees,
   output logic [6:0] rsp_lon_minutes,
   output logic [5:0] rsp_lon_seconds
);

   logic         in_valid;
   logic [7:0]   in_char;
   logic         emit;
   logic         out_free;
   logic         advance;
   logic         load;
   gptp_rec_type rec;
   gptp_rec_type rsp_rec;

   gptp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_char (req_in_char),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_char     (in_char)
   );

   gptp_parse #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_char (in_char),
      .emit    (emit),
      .rec     (rec)
   );

   // Consume the held character unless its record has nowhere to go
   assign advance = in_valid && (!emit || out_free);
   assign load    = advance && emit;

   gptp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .rec       (rec),
      .out_free  (out_free),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_time_hour        = rsp_rec.time_hour;
   assign rsp_time_minute      = rsp_rec.time_minute;
   assign rsp_time_second      = rsp_rec.time_second;
   assign rsp_time_millisecond = rsp_rec.time_millisecond;
   assign rsp_lat_hemi_char    = rsp_rec.lat_hemi_char;
   assign rsp_lat_degrees      = rsp_rec.lat_degrees;
   assign rsp_lat_minutes      = rsp_rec.lat_minutes;
   assign rsp_lat_seconds      = rsp_rec.lat_seconds;
   assign rsp_lon_hemi_char    = rsp_rec.lon_hemi_char;
   assign rsp_lon_degrees      = rsp_rec.lon_degrees;
   assign rsp_lon_minutes      = rsp_rec.lon_minutes;
   assign rsp_lon_seconds      = rsp_rec.lon_seconds;

   `GPTP_ASSERT_NEXT(a_emit_loads, load, rsp_valid, "closed record not presented")
   `GPTP_ASSERT(a_no_overwrite, !(load && rsp_valid && !rsp_ready),
      "record overwritten before transfer")
   `GPTP_ASSERT(a_stall_blocks_input, !(in_valid && !advance && req_ready),
      "input taken while held character is stalled")

endmodule
